// ===== rtl/assert_macros.svh =====
// assertion macros used by the block's controller
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/lmp_pkg.sv =====
// types and constants of the limb middle product block
// no dependencies
`timescale 1ns / 1ps

package lmp_pkg;

  localparam int LIMB_W      = 52;
  localparam int HALF_W      = LIMB_W / 2;
  localparam int PROD_W      = 2 * LIMB_W;
  localparam int WORD_W      = 64;
  localparam int MAX_COEFFS  = 64;
  localparam int COEFF_AW    = $clog2(MAX_COEFFS);
  localparam int DIGIT_DEPTH = 2 * MAX_COEFFS;
  localparam int DIGIT_AW    = $clog2(DIGIT_DEPTH);
  localparam int CNT_W       = 7;
  localparam int STEP_W      = COEFF_AW + 1;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(24);
  localparam logic [CNT_W-1:0] CNT_MAX     = CNT_W'(MAX_COEFFS);
  localparam logic [CNT_W-1:0] CNT_SAT     = CNT_W'(MAX_COEFFS + 1);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_PUSH  = 2'd2
  } cmd_code_t;

  typedef struct packed {
    logic                coef_we;
    logic [COEFF_AW-1:0] coef_waddr;
    logic                digit_we;
    logic [DIGIT_AW-1:0] digit_waddr;
    logic                rd_valid;
    logic [COEFF_AW-1:0] rd_coef_addr;
    logic [DIGIT_AW-1:0] rd_digit_addr;
    logic                rd_zero;
    logic                rd_hi;
    logic                acc_clear;
    logic                out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_status_t;

endpackage

// ===== rtl/lmp_in_if.sv =====
// input channel of the limb middle product block
// depends on lmp_pkg
`timescale 1ns / 1ps

interface lmp_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 cmd;
  logic [lmp_pkg::COEFF_AW-1:0] coeff_index;
  logic [lmp_pkg::LIMB_W-1:0]   limb_value;

  modport source (output valid, output cmd, output coeff_index, output limb_value,
                  input ready);
  modport sink (input valid, input cmd, input coeff_index, input limb_value,
                output ready);
endinterface

// ===== rtl/lmp_out_if.sv =====
// output channel of the limb middle product block
// depends on lmp_pkg
`timescale 1ns / 1ps

interface lmp_out_if;
  logic                       valid;
  logic                       ready;
  logic [lmp_pkg::WORD_W-1:0] product_word;

  modport source (output valid, output product_word, input ready);
  modport sink (input valid, input product_word, output ready);
endinterface

// ===== rtl/lmp_ram.sv =====
// generic simple dual-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module lmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lmp_dp.sv =====
// datapath: coefficient and digit rams, product pipeline, accumulator
// depends on lmp_pkg and lmp_ram
`timescale 1ns / 1ps

module lmp_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  lmp_pkg::ctrl_cmd_t         cmd,
  input  logic [lmp_pkg::LIMB_W-1:0] limb_value,
  output lmp_pkg::dp_status_t        status,
  output logic [lmp_pkg::WORD_W-1:0] product_word
);

  localparam int HW = lmp_pkg::HALF_W;
  localparam int LW = lmp_pkg::LIMB_W;

  logic [LW-1:0]              coef_q;
  logic [LW-1:0]              digit_q;
  logic                       r_valid, r_zero, r_hi;
  logic [LW-1:0]              op_d;
  logic [LW-1:0]              p00, p01, p10, p11;
  logic                       m_valid, m_hi;
  logic [LW:0]                mid;
  logic [lmp_pkg::PROD_W-1:0] prod;
  logic [LW-1:0]              c_term;
  logic                       c_valid;
  logic [lmp_pkg::WORD_W-1:0] acc;

  lmp_ram #(.WIDTH(LW), .DEPTH(lmp_pkg::MAX_COEFFS)) u_coef_ram (
    .clk   (clk),
    .we    (cmd.coef_we),
    .waddr (cmd.coef_waddr),
    .wdata (limb_value),
    .raddr (cmd.rd_coef_addr),
    .rdata (coef_q)
  );

  lmp_ram #(.WIDTH(LW), .DEPTH(lmp_pkg::DIGIT_DEPTH)) u_digit_ram (
    .clk   (clk),
    .we    (cmd.digit_we),
    .waddr (cmd.digit_waddr),
    .wdata (limb_value),
    .raddr (cmd.rd_digit_addr),
    .rdata (digit_q)
  );

  // digits from before the start read as zero
  assign op_d = r_zero ? '0 : digit_q;
  assign mid  = {1'b0, p01} + {1'b0, p10};
  assign prod = {p11, p00} + ({(lmp_pkg::PROD_W - LW - 1)'(0), mid} << HW);

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      m_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      r_valid <= cmd.rd_valid;
      m_valid <= r_valid;
      c_valid <= m_valid;
    end
    r_zero <= cmd.rd_zero;
    r_hi   <= cmd.rd_hi;
    p00    <= coef_q[HW-1:0]  * op_d[HW-1:0];
    p01    <= coef_q[HW-1:0]  * op_d[LW-1:HW];
    p10    <= coef_q[LW-1:HW] * op_d[HW-1:0];
    p11    <= coef_q[LW-1:HW] * op_d[LW-1:HW];
    m_hi   <= r_hi;
    c_term <= m_hi ? prod[lmp_pkg::PROD_W-1:LW] : prod[LW-1:0];
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (c_valid) begin
      acc <= acc + lmp_pkg::WORD_W'(c_term);
    end
    if (cmd.out_load) begin
      product_word <= acc;
    end
  end

  assign status.pipe_busy = r_valid | m_valid | c_valid;

endmodule

// ===== rtl/lmp_ctrl.sv =====
// controller: command decode, digit ring pointer, product sequencing
// depends on lmp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lmp_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lmp_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  input  logic [1:0]                    in_cmd,
  input  logic [lmp_pkg::COEFF_AW-1:0]  in_index,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lmp_pkg::ctrl_cmd_t            cmd,
  input  lmp_pkg::dp_status_t           status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t                         state;
  logic [lmp_pkg::CNT_W-1:0]      coeff_count;
  logic [lmp_pkg::DIGIT_AW-1:0]   wp;
  logic [lmp_pkg::CNT_W-1:0]      cnt;
  logic [lmp_pkg::STEP_W-1:0]     step;

  logic [lmp_pkg::CNT_W-1:0]      n_act;
  logic [lmp_pkg::CNT_W-1:0]      n_m1;
  logic [lmp_pkg::STEP_W-1:0]     last_step;
  logic [lmp_pkg::CNT_W-1:0]      cnt_inc;
  logic [lmp_pkg::CNT_W-1:0]      k;
  logic                           accept;
  logic                           emit;
  logic                           out_free;

  always_comb begin
    if (coeff_count == '0) begin
      n_act = lmp_pkg::CNT_W'(1);
    end else if (coeff_count > lmp_pkg::CNT_MAX) begin
      n_act = lmp_pkg::CNT_MAX;
    end else begin
      n_act = coeff_count;
    end
  end

  assign n_m1      = n_act - lmp_pkg::CNT_W'(1);
  assign last_step = {n_m1[lmp_pkg::COEFF_AW-1:0], 1'b1};
  assign cnt_inc   = (cnt == lmp_pkg::CNT_SAT) ? cnt : cnt + lmp_pkg::CNT_W'(1);
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign emit      = (in_cmd == lmp_pkg::CMD_PUSH) && (cnt_inc >= n_act);
  assign out_free  = !out_valid || out_ready;
  // digit age: even steps take the low half, odd steps the high half
  assign k = lmp_pkg::CNT_W'(step[lmp_pkg::STEP_W-1:1]) + lmp_pkg::CNT_W'(step[0]);

  always_comb begin
    cmd               = '0;
    cmd.coef_waddr    = in_index;
    cmd.digit_waddr   = wp + lmp_pkg::DIGIT_AW'(1);
    cmd.rd_coef_addr  = step[lmp_pkg::STEP_W-1:1];
    cmd.rd_digit_addr = wp - lmp_pkg::DIGIT_AW'(k);
    cmd.rd_zero       = (k >= cnt);
    cmd.rd_hi         = step[0];
    cmd.rd_valid      = (state == S_RUN);
    cmd.out_load      = (state == S_DRAIN) && !status.pipe_busy && out_free;
    if (accept) begin
      case (in_cmd)
        lmp_pkg::CMD_LOAD: begin
          cmd.coef_we = 1'b1;
        end
        lmp_pkg::CMD_PUSH: begin
          cmd.digit_we  = 1'b1;
          cmd.acc_clear = emit;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      coeff_count <= lmp_pkg::COUNT_RESET;
      wp          <= '0;
      cnt         <= '0;
      step        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        coeff_count <= cfg_wdata;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_cmd)
              lmp_pkg::CMD_START: begin
                cnt <= '0;
              end
              lmp_pkg::CMD_PUSH: begin
                wp  <= wp + lmp_pkg::DIGIT_AW'(1);
                cnt <= cnt_inc;
                if (emit) begin
                  step  <= '0;
                  state <= S_RUN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RUN: begin
          step <= step + lmp_pkg::STEP_W'(1);
          if (step == last_step) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!status.pipe_busy && out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMP(a_load_when_drained, clk, rst, cmd.out_load, !status.pipe_busy && state == S_DRAIN)
  `ASSERT_IMP(a_cnt_bounded, clk, rst, 1'b1, cnt <= lmp_pkg::CNT_SAT)
  `ASSERT_NXT(a_emit_starts_run, clk, rst, accept && emit, state == S_RUN && step == '0)
  `ASSERT_IMP(a_no_write_while_run, clk, rst, cmd.rd_valid, !cmd.coef_we && !cmd.digit_we)

endmodule

// ===== rtl/limb_middle_product_52.sv =====
// top level of the limb middle product block
// depends on lmp_pkg, lmp_in_if, lmp_out_if, lmp_ctrl and lmp_dp
`timescale 1ns / 1ps

// Load, start and pushes that give no word are each taken in the idle state. A
// push that gives a word (once n digits are in since the start) holds the input,
// for n coefficients, until its word is loaded into the output register, and
// that load comes later while the previous word still waits: one shared
// 52x52 product unit, built from four 26x26 partial products, runs once per
// coefficient for the low half and once for the high half, followed by a
// pipeline drain. The coefficient and digit stores are single-read rams;
// digits sit in a ring of twice the coefficient capacity. A finished
// word waits in an output register while the next words are accepted.
module limb_middle_product_52 (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [lmp_pkg::CNT_W-1:0] cfg_wdata,
  lmp_in_if.sink                    items,
  lmp_out_if.source                 results
);

  lmp_pkg::ctrl_cmd_t  cmd;
  lmp_pkg::dp_status_t status;
  logic                in_ready;
  logic                out_valid;

  lmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (items.valid),
    .in_cmd    (items.cmd),
    .in_index  (items.coeff_index),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .status    (status)
  );

  lmp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .limb_value   (items.limb_value),
    .status       (status),
    .product_word (results.product_word)
  );

  assign items.ready   = in_ready;
  assign results.valid = out_valid;

endmodule
